// ===== rtl/binary_max_heap_priority_queue_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the heap priority queue
// Concurrent assertion wrappers; they expand to nothing in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef BINARY_MAX_HEAP_PRIORITY_QUEUE_DEFINES_SVH
`define BINARY_MAX_HEAP_PRIORITY_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define BMHPQ_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// Condition must never be true outside reset.
`define BMHPQ_ASSERT_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define BMHPQ_ASSERT(name, clk, rst_n, prop)
`define BMHPQ_ASSERT_NEVER(name, clk, rst_n, cond)
`endif

`endif

// ===== rtl/bmhpq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmhpq_pkg
// Types and constants shared by the heap priority queue.
// ----------------------------------------------------------------------------
package bmhpq_pkg;

  localparam int DefCapacity = 1024;
  localparam int IdW         = 32;
  localparam int PrioW       = 32;
  localparam int FillW       = 11;
  localparam int EntryW      = IdW + PrioW;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP,
    S_POP_LD,
    S_DOWN,
    S_FIN,
    S_RESP
  } state_e;

  // One heap word: id in the upper half, priority in the lower half.
  typedef struct packed {
    logic [IdW-1:0]          id;
    logic signed [PrioW-1:0] prio;
  } entry_t;

  typedef struct packed {
    op_e                     operation;
    logic [IdW-1:0]          proc_id;
    logic signed [PrioW-1:0] priority_req;
  } req_t;

  typedef struct packed {
    status_e                 status;
    logic [IdW-1:0]          out_proc_id;
    logic signed [PrioW-1:0] out_priority;
    logic [FillW-1:0]        fill_count;
  } rsp_t;

endpackage

// ===== rtl/bmhpq_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmhpq_ram
// Generic RAM with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module bmhpq_ram #(
  parameter int Width = 64,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  output logic [Width-1:0]         rdata_a_o,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

// ===== rtl/binary_max_heap_priority_queue.sv =====
`timescale 1ns / 1ps
// An accepted push passes S_UP, a pop S_POP_LD then S_DOWN, staying while the
// entry moves a level, then S_FIN if it reached the root or a leaf, then S_RESP
// and the output register; a refused item, a push into an empty heap and a pop
// leaving at most one entry (after S_POP_LD) go straight to S_RESP. Throughput:
// one item at a time, with one read-compare-write of the heap RAM per level.
// Reset clears the entry count and the handshake state, not the heap RAM.
// ----------------------------------------------------------------------------
// binary_max_heap_priority_queue
// Max-heap priority queue of (id, signed priority) entries held in one RAM.
// ----------------------------------------------------------------------------
`include "binary_max_heap_priority_queue_defines.svh"

module binary_max_heap_priority_queue #(
  parameter int CAPACITY = bmhpq_pkg::DefCapacity
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  bmhpq_pkg::req_t   in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output bmhpq_pkg::rsp_t   out_data_o
);

  // AW addresses the RAM, CW holds a count up to CAPACITY, and IW is wide
  // enough for child indexes 2*pos+2 without overflow.
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = AW + 2;
  localparam int FW = bmhpq_pkg::FillW;

  bmhpq_pkg::state_e state_q, state_d;
  logic [CW-1:0]     count_q, count_d;
  logic [AW-1:0]     pos_q, pos_d;
  bmhpq_pkg::entry_t cur_q, cur_d;
  bmhpq_pkg::rsp_t   rsp_q, rsp_d;
  bmhpq_pkg::rsp_t   out_q, out_d;
  logic              out_valid_q, out_valid_d;

  // RAM interface.
  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr_a, ram_raddr_b;
  bmhpq_pkg::entry_t ram_wdata, rd_a, rd_b;

  bmhpq_ram #(
    .Width (bmhpq_pkg::EntryW),
    .Depth (CAPACITY)
  ) u_heap_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .raddr_a_i (ram_raddr_a),
    .rdata_a_o (rd_a),
    .raddr_b_i (ram_raddr_b),
    .rdata_b_o (rd_b)
  );

  // Handshake and status of the queue.
  logic accept, is_push, full, empty, out_load;

  assign in_ready_o = (state_q == bmhpq_pkg::S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign is_push    = (in_data_i.operation == bmhpq_pkg::OP_PUSH);
  assign full       = (count_q == CW'(CAPACITY));
  assign empty      = (count_q == '0);
  // The pending result moves to the output register once it is free.
  assign out_load   = (state_q == bmhpq_pkg::S_RESP) && (!out_valid_q || out_ready_i);

  // Sift up: the moving entry sits in cur_q, the parent word arrives on port A.
  logic [AW-1:0] tail_parent, up_parent;
  logic          up_move, up_more;

  assign tail_parent = (AW'(count_q) - AW'(1)) >> 1;
  assign up_parent   = (pos_q - AW'(1)) >> 1;
  assign up_move     = (cur_q.prio > rd_a.prio);
  assign up_more     = (up_parent != '0);

  // Sift down: left child on port A, right child on port B. A child only
  // moves up when strictly greater, and on a tie the left child wins.
  logic [IW-1:0] cnt_ext, left_w, right_w, nleft_w, nright_w;
  logic          left_v, right_v, lgt, rgt, dn_move, dn_more;
  logic [AW-1:0] best_idx;
  logic signed [bmhpq_pkg::PrioW-1:0] cmp_prio;
  bmhpq_pkg::entry_t best_data;

  assign cnt_ext  = IW'(count_q);
  assign left_w   = IW'({pos_q, 1'b1});
  assign right_w  = left_w + IW'(1);
  assign left_v   = (left_w < cnt_ext);
  assign right_v  = (right_w < cnt_ext);
  assign lgt      = left_v && (rd_a.prio > cur_q.prio);
  assign cmp_prio = lgt ? rd_a.prio : cur_q.prio;
  assign rgt      = right_v && (rd_b.prio > cmp_prio);
  assign dn_move  = lgt || rgt;
  assign best_idx = rgt ? right_w[AW-1:0] : left_w[AW-1:0];
  assign best_data = rgt ? rd_b : rd_a;
  assign nleft_w  = IW'({best_idx, 1'b1});
  assign nright_w = nleft_w + IW'(1);
  assign dn_more  = (nleft_w < cnt_ext);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      bmhpq_pkg::S_IDLE: begin
        if (accept) begin
          if (is_push) begin
            state_d = (full || empty) ? bmhpq_pkg::S_RESP : bmhpq_pkg::S_UP;
          end else begin
            state_d = empty ? bmhpq_pkg::S_RESP : bmhpq_pkg::S_POP_LD;
          end
        end
      end
      bmhpq_pkg::S_UP: begin
        if (!up_move) begin
          state_d = bmhpq_pkg::S_RESP;
        end else if (!up_more) begin
          state_d = bmhpq_pkg::S_FIN;
        end
      end
      bmhpq_pkg::S_POP_LD: begin
        state_d = (IW'(1) < cnt_ext) ? bmhpq_pkg::S_DOWN : bmhpq_pkg::S_RESP;
      end
      bmhpq_pkg::S_DOWN: begin
        if (!dn_move) begin
          state_d = bmhpq_pkg::S_RESP;
        end else if (!dn_more) begin
          state_d = bmhpq_pkg::S_FIN;
        end
      end
      bmhpq_pkg::S_FIN: begin
        state_d = bmhpq_pkg::S_RESP;
      end
      bmhpq_pkg::S_RESP: begin
        if (out_load) begin
          state_d = bmhpq_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = bmhpq_pkg::S_IDLE;
      end
    endcase
  end

  // Datapath, RAM control and result.
  always_comb begin
    count_d     = count_q;
    pos_d       = pos_q;
    cur_d       = cur_q;
    rsp_d       = rsp_q;
    ram_we      = 1'b0;
    ram_waddr   = pos_q;
    ram_wdata   = cur_q;
    ram_raddr_a = '0;
    ram_raddr_b = '0;
    out_d       = out_load ? rsp_q : out_q;
    out_valid_d = out_load || (out_valid_q && !out_ready_i);

    case (state_q)
      bmhpq_pkg::S_IDLE: begin
        if (accept) begin
          rsp_d.status       = bmhpq_pkg::ST_OK;
          rsp_d.out_proc_id  = '0;
          rsp_d.out_priority = '0;
          rsp_d.fill_count   = FW'(count_q);
          if (is_push) begin
            if (full) begin
              rsp_d.status = bmhpq_pkg::ST_FULL;
            end else begin
              cur_d.id         = in_data_i.proc_id;
              cur_d.prio       = in_data_i.priority_req;
              pos_d            = AW'(count_q);
              count_d          = count_q + CW'(1);
              rsp_d.fill_count = FW'(count_q + CW'(1));
              ram_raddr_a      = tail_parent;
              // The first entry has no parent and goes straight to the root.
              if (empty) begin
                ram_we         = 1'b1;
                ram_waddr      = '0;
                ram_wdata.id   = in_data_i.proc_id;
                ram_wdata.prio = in_data_i.priority_req;
              end
            end
          end else begin
            if (empty) begin
              rsp_d.status = bmhpq_pkg::ST_EMPTY;
            end else begin
              // Fetch the root and the last entry together.
              ram_raddr_a      = '0;
              ram_raddr_b      = AW'(count_q - CW'(1));
              count_d          = count_q - CW'(1);
              rsp_d.fill_count = FW'(count_q - CW'(1));
            end
          end
        end
      end
      bmhpq_pkg::S_UP: begin
        if (up_move) begin
          // Parent moves down into the hole; the hole climbs.
          ram_we      = 1'b1;
          ram_wdata   = rd_a;
          pos_d       = up_parent;
          ram_raddr_a = (up_parent - AW'(1)) >> 1;
        end else begin
          ram_we = 1'b1;
        end
      end
      bmhpq_pkg::S_POP_LD: begin
        rsp_d.out_proc_id  = rd_a.id;
        rsp_d.out_priority = rd_a.prio;
        cur_d              = rd_b;
        pos_d              = '0;
        ram_raddr_a        = AW'(1);
        ram_raddr_b        = AW'(2);
        // With one entry left, the former last entry simply becomes the root.
        if (count_q == CW'(1)) begin
          ram_we    = 1'b1;
          ram_waddr = '0;
          ram_wdata = rd_b;
        end
      end
      bmhpq_pkg::S_DOWN: begin
        if (dn_move) begin
          ram_we      = 1'b1;
          ram_wdata   = best_data;
          pos_d       = best_idx;
          ram_raddr_a = nleft_w[AW-1:0];
          ram_raddr_b = nright_w[AW-1:0];
        end else begin
          ram_we = 1'b1;
        end
      end
      bmhpq_pkg::S_FIN: begin
        ram_we = 1'b1;
      end
      bmhpq_pkg::S_RESP: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bmhpq_pkg::S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    cur_q <= cur_d;
    rsp_q <= rsp_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The count never runs past the capacity.
  `BMHPQ_ASSERT(a_count_range, clk_i, rst_ni, count_q <= CW'(CAPACITY))
  // A successful pop lowers the count by exactly one on the next cycle.
  `BMHPQ_ASSERT(a_pop_count, clk_i, rst_ni,
                (accept && !is_push && !empty) |=> (count_q == $past(count_q) - CW'(1)))
  // A new result only ever comes from the response state.
  `BMHPQ_ASSERT(a_out_from_resp, clk_i, rst_ni,
                $rose(out_valid_q) |-> $past(state_q == bmhpq_pkg::S_RESP))
  // Sifting down only ever works on a position inside the heap.
  `BMHPQ_ASSERT(a_down_in_range, clk_i, rst_ni,
                (state_q == bmhpq_pkg::S_DOWN) |-> (IW'(pos_q) < cnt_ext))
  // No RAM write while a result waits.
  `BMHPQ_ASSERT_NEVER(a_no_write_resp, clk_i, rst_ni,
                      ram_we && (state_q == bmhpq_pkg::S_RESP))

endmodule
